>>> hw/rtl/svg_pkg.sv
// Shared types and constants of the state vector gate engine.
// Depends on nothing; every RTL file but svg_amp_ram imports it.
`default_nettype none
package svg_pkg;

  localparam int NUM_QUBITS = 10;
  localparam int ADDR_W     = NUM_QUBITS;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int AMP_W      = 32;
  localparam int ACC_W      = 2 * AMP_W + ADDR_W;
  localparam int NUM_REGS   = 8;

  localparam logic signed [AMP_W-1:0] Q_ONE    = 32'sh4000_0000;
  localparam logic        [30:0]      PROB_SAT = 31'h7FFF_FFFF;

  // register indexes of the configuration port
  localparam logic [3:0] REG_G00_RE = 4'd0;
  localparam logic [3:0] REG_G00_IM = 4'd1;
  localparam logic [3:0] REG_G01_RE = 4'd2;
  localparam logic [3:0] REG_G01_IM = 4'd3;
  localparam logic [3:0] REG_G10_RE = 4'd4;
  localparam logic [3:0] REG_G10_IM = 4'd5;
  localparam logic [3:0] REG_G11_RE = 4'd6;
  localparam logic [3:0] REG_G11_IM = 4'd7;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_GATE = 2'd1,
    OP_READ = 2'd2,
    OP_PROB = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] re;
    logic signed [AMP_W-1:0] im;
  } amp_t;

  localparam amp_t AMP_ONE  = '{re: Q_ONE, im: '0};
  localparam amp_t AMP_ZERO = '{re: '0, im: '0};

  typedef struct packed {
    logic signed [AMP_W-1:0] g00r;
    logic signed [AMP_W-1:0] g00i;
    logic signed [AMP_W-1:0] g01r;
    logic signed [AMP_W-1:0] g01i;
    logic signed [AMP_W-1:0] g10r;
    logic signed [AMP_W-1:0] g10i;
    logic signed [AMP_W-1:0] g11r;
    logic signed [AMP_W-1:0] g11i;
  } gate_t;

  // comp: 0 new a real, 1 new a imag, 2 new b real, 3 new b imag
  typedef struct packed {
    logic       mul_en;
    logic [1:0] comp;
  } mac_ctrl_t;

  typedef struct packed {
    logic clr;
    logic take;
  } prob_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/state_vector_gate_engine.sv
// State vector gate engine: 2^N Q2.30 amplitudes in one RAM, read-modify-write.
// A gate walks the 2^(N-1) amplitude pairs; a pair outside the control is skipped.
// One item at a time, set by the sequencer around the one-read, one-write RAM.
// Reset: a clearing pass writes the initial state; items wait,
// configuration beats are taken throughout.
`default_nettype none
module state_vector_gate_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  target_qubit,
  input  wire logic [3:0]  control_qubit,
  input  wire logic        use_control,
  input  wire logic [9:0]  amp_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       done_op,
  output logic signed [31:0] amp_real,
  output logic signed [31:0] amp_imag,
  output logic [30:0]      prob_zero,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import svg_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ_WAIT, S_G_RD_A, S_G_RD_B, S_G_WAIT, S_G_CALC,
    S_G_WR_A, S_G_WR_B, S_P_RUN, S_P_DRAIN, S_DONE
  } state_t;

  localparam logic [ADDR_W-1:0] TOP_BIT   = ADDR_W'(DEPTH / 2);
  localparam logic [ADDR_W-1:0] LAST_PAIR = ADDR_W'(DEPTH / 2 - 1);

  state_t state;
  logic [ADDR_W-1:0] cnt, tmask, cmask, ia_q, ib_q;
  logic [2:0] phase;
  logic drain, init_item, uc_q, take_q;
  op_t op_q;
  amp_t a_q, b_q, res_amp;
  gate_t gate;

  logic in_beat;
  logic [ADDR_W-1:0] tmask_in, cmask_in, lowmask, ia, ib;
  logic skip, gate_noop;

  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  amp_t ram_wdata, ram_rdata, new_a, new_b;
  mac_ctrl_t mac_ctrl;
  prob_ctrl_t prob_ctrl;
  logic [30:0] prob_val;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;

  // shifting past the last index bit leaves an empty mask
  assign tmask_in  = TOP_BIT >> target_qubit;
  assign cmask_in  = TOP_BIT >> control_qubit;
  assign gate_noop = (tmask_in == '0) ||
                     (use_control && ((cmask_in == '0) || (control_qubit == target_qubit)));

  // open a zero at the target bit of the pair count
  assign lowmask = tmask - 1'b1;
  assign ia      = ((cnt & ~lowmask) << 1) | (cnt & lowmask);
  assign ib      = ia | tmask;
  assign skip    = uc_q && ((ia & cmask) == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = AMP_ZERO;
    ram_re    = 1'b0;
    ram_raddr = cnt;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt == '0) ? AMP_ONE : AMP_ZERO;
      end
      S_IDLE: begin
        ram_re    = in_valid;
        ram_raddr = ADDR_W'(amp_index);
      end
      S_G_RD_A: begin
        ram_re    = ~skip;
        ram_raddr = ia;
      end
      S_G_RD_B: begin
        ram_re    = 1'b1;
        ram_raddr = ib_q;
      end
      S_G_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = ia_q;
        ram_wdata = new_a;
      end
      S_G_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = ib_q;
        ram_wdata = new_b;
      end
      S_P_RUN: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mac_ctrl.mul_en = (state == S_G_CALC) && (phase != 3'd4);
  assign mac_ctrl.comp   = phase[1:0];
  assign prob_ctrl.clr   = in_beat && (op_t'(op) == OP_PROB);
  assign prob_ctrl.take  = take_q;

  svg_amp_ram #(.ADDR_W(ADDR_W), .DATA_W(2 * AMP_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  svg_gate_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .gate  (gate),
    .a     (a_q),
    .b     (b_q),
    .ctrl  (mac_ctrl),
    .new_a (new_a),
    .new_b (new_b)
  );

  svg_prob_acc u_prob (
    .clk  (clk),
    .rst  (rst),
    .ctrl (prob_ctrl),
    .data (ram_rdata),
    .prob (prob_val)
  );

  // gate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate <= '{g00r: Q_ONE, g11r: Q_ONE, default: '0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_G00_RE: gate.g00r <= cfg_data;
        REG_G00_IM: gate.g00i <= cfg_data;
        REG_G01_RE: gate.g01r <= cfg_data;
        REG_G01_IM: gate.g01i <= cfg_data;
        REG_G10_RE: gate.g10r <= cfg_data;
        REG_G10_IM: gate.g10i <= cfg_data;
        REG_G11_RE: gate.g11r <= cfg_data;
        REG_G11_IM: gate.g11i <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      phase     <= '0;
      drain     <= 1'b0;
      init_item <= 1'b0;
      take_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      take_q <= (state == S_P_RUN) && ((cnt & tmask) == '0);
      // a new result beat in completion takes over the slot instead
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (&cnt) begin
            state <= init_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            op_q      <= op_t'(op);
            uc_q      <= use_control;
            tmask     <= tmask_in;
            cmask     <= cmask_in;
            cnt       <= '0;
            init_item <= 1'b0;
            drain     <= 1'b0;
            case (op_t'(op))
              OP_INIT: begin
                init_item <= 1'b1;
                state     <= S_CLEAR;
              end
              OP_GATE: state <= gate_noop ? S_DONE : S_G_RD_A;
              OP_READ: state <= S_READ_WAIT;
              default: state <= S_P_RUN;
            endcase
          end
        end
        S_READ_WAIT: begin
          res_amp <= ram_rdata;
          state   <= S_DONE;
        end
        S_G_RD_A: begin
          ia_q <= ia;
          ib_q <= ib;
          if (!skip) begin
            state <= S_G_RD_B;
          end else if (cnt == LAST_PAIR) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_G_RD_B: begin
          a_q   <= ram_rdata;
          state <= S_G_WAIT;
        end
        S_G_WAIT: begin
          b_q   <= ram_rdata;
          phase <= '0;
          state <= S_G_CALC;
        end
        S_G_CALC: begin
          // last component leaves the sum stage at the end of phase four
          if (phase == 3'd4) begin
            state <= S_G_WR_A;
          end else begin
            phase <= phase + 1'b1;
          end
        end
        S_G_WR_A: state <= S_G_WR_B;
        S_G_WR_B: begin
          if (cnt == LAST_PAIR) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_G_RD_A;
          end
        end
        S_P_RUN: begin
          cnt <= cnt + 1'b1;
          if (&cnt) begin
            state <= S_P_DRAIN;
          end
        end
        S_P_DRAIN: begin
          // drains the last squares, then the final add
          drain <= 1'b1;
          if (drain) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            done_op   <= op_q;
            amp_real  <= (op_q == OP_READ) ? res_amp.re : '0;
            amp_imag  <= (op_q == OP_READ) ? res_amp.im : '0;
            prob_zero <= (op_q == OP_PROB) ? prob_val : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state != S_IDLE))
    else $error("engine stayed idle after taking an item");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_we)
    else $error("store written outside an item");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside completion");

  a_amp_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (done_op != OP_READ)) |-> (amp_real == '0 && amp_imag == '0))
    else $error("amplitude fields set on a non-read result");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/svg_amp_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// Holds the amplitude store; no dependencies.
`default_nettype none
module svg_amp_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/svg_gate_mac.sv
// Complex 2x2 gate datapath: four multipliers, then sum, round and saturate.
// One output component per cycle while ctrl.mul_en is high, two-stage pipeline. Uses svg_pkg.
`default_nettype none
module svg_gate_mac (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire svg_pkg::gate_t    gate,
  input  wire svg_pkg::amp_t     a,
  input  wire svg_pkg::amp_t     b,
  input  wire svg_pkg::mac_ctrl_t ctrl,
  output svg_pkg::amp_t          new_a,
  output svg_pkg::amp_t          new_b
);
  import svg_pkg::*;

  logic signed [AMP_W-1:0] xr, xi, yr, yi;
  logic signed [AMP_W-1:0] m0b, m1b, m2b, m3b;
  logic odd;
  logic signed [2*AMP_W-1:0] p0, p1, p2, p3;
  logic neg_q;
  logic [1:0] comp_q;
  logic mv;
  logic signed [2*AMP_W+1:0] s, r;
  logic signed [AMP_W-1:0] sat;

  assign odd = ctrl.comp[0];

  always_comb begin
    if (ctrl.comp[1]) begin
      xr = gate.g10r; xi = gate.g10i; yr = gate.g11r; yi = gate.g11i;
    end else begin
      xr = gate.g00r; xi = gate.g00i; yr = gate.g01r; yi = gate.g01i;
    end
    m0b = odd ? a.im : a.re;
    m1b = odd ? a.re : a.im;
    m2b = odd ? b.im : b.re;
    m3b = odd ? b.re : b.im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= ctrl.mul_en;
    end
    if (ctrl.mul_en) begin
      p0     <= 64'(xr) * 64'(m0b);
      p1     <= 64'(xi) * 64'(m1b);
      p2     <= 64'(yr) * 64'(m2b);
      p3     <= 64'(yi) * 64'(m3b);
      neg_q  <= ~odd;
      comp_q <= ctrl.comp;
    end
  end

  // real parts subtract the imaginary-by-imaginary terms
  always_comb begin
    s = 66'(p0) + (neg_q ? -66'(p1) : 66'(p1))
      + 66'(p2) + (neg_q ? -66'(p3) : 66'(p3));
    r = (s + 66'sd536870912) >>> 30;
    if (r > 66'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (r < -66'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = r[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      case (comp_q)
        2'd0:    new_a.re <= sat;
        2'd1:    new_a.im <= sat;
        2'd2:    new_b.re <= sat;
        default: new_b.im <= sat;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/svg_prob_acc.sv
// Squared-magnitude accumulator for the probability of zero.
// Squares in one stage, exact sum in the next, rounded and saturated output. Uses svg_pkg.
`default_nettype none
module svg_prob_acc (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire svg_pkg::prob_ctrl_t ctrl,
  input  wire svg_pkg::amp_t      data,
  output logic [30:0]             prob
);
  import svg_pkg::*;

  logic signed [2*AMP_W-1:0] sq_re, sq_im;
  logic v1;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rnd;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      v1  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= ctrl.take;
      if (v1) begin
        acc <= acc + ACC_W'(unsigned'(sq_re)) + ACC_W'(unsigned'(sq_im));
      end
    end
    if (ctrl.take) begin
      sq_re <= 64'(data.re) * 64'(data.re);
      sq_im <= 64'(data.im) * 64'(data.im);
    end
  end

  always_comb begin
    rnd = (acc + ACC_W'(32'd536870912)) >> 30;
    if (rnd > ACC_W'(PROB_SAT)) begin
      prob = PROB_SAT;
    end else begin
      prob = rnd[30:0];
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench of the state vector gate engine: directed and random items,
// each result checked against a behavioural amplitude store kept here.
// Depends on svg_pkg and state_vector_gate_engine.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import svg_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS  = 560;
  localparam logic signed [31:0] HADA = 32'sd759250125;
  localparam logic [3:0] REG_IDX [NUM_REGS] = '{REG_G00_RE, REG_G00_IM, REG_G01_RE,
      REG_G01_IM, REG_G10_RE, REG_G10_IM, REG_G11_RE, REG_G11_IM};

  typedef struct {
    op_t         op;
    logic [31:0] re;
    logic [31:0] im;
    logic [30:0] prob;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  op_t op = OP_INIT;
  logic [3:0] target_qubit = '0;
  logic [3:0] control_qubit = '0;
  logic use_control = 1'b0;
  logic [9:0] amp_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] done_op;
  logic signed [31:0] amp_real;
  logic signed [31:0] amp_imag;
  logic [30:0] prob_zero;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] store_re [DEPTH];
  logic signed [31:0] store_im [DEPTH];
  logic signed [31:0] gate_m [NUM_REGS];
  outcome_t outcome_q [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  state_vector_gate_engine DUT (
    .clk, .rst, .in_valid, .in_ready, .op, .target_qubit, .control_qubit,
    .use_control, .amp_index, .out_valid, .out_ready, .done_op, .amp_real,
    .amp_imag, .prob_zero, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- behavioural store ----------------
  function automatic logic signed [31:0] round_q(input logic signed [67:0] s);
    logic signed [67:0] r;
    r = (s + 68'sd536870912) >>> 30;
    if (r > 68'sd2147483647) return 32'sh7FFF_FFFF;
    if (r < -68'sd2147483648) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  // x*a + y*b, complex; x at register rx, y at ry
  task automatic mix_pair(input int rx, input int ry, input logic signed [31:0] ar,
                          input logic signed [31:0] ai, input logic signed [31:0] br,
                          input logic signed [31:0] bi, output logic signed [31:0] nr,
                          output logic signed [31:0] ni);
    logic signed [67:0] s;
    s = longint'(gate_m[rx]) * longint'(ar);
    s = s - longint'(gate_m[rx+1]) * longint'(ai);
    s = s + longint'(gate_m[ry]) * longint'(br);
    s = s - longint'(gate_m[ry+1]) * longint'(bi);
    nr = round_q(s);
    s = longint'(gate_m[rx]) * longint'(ai);
    s = s + longint'(gate_m[rx+1]) * longint'(ar);
    s = s + longint'(gate_m[ry]) * longint'(bi);
    s = s + longint'(gate_m[ry+1]) * longint'(br);
    ni = round_q(s);
  endtask

  task automatic clear_store();
    for (int i = 0; i < DEPTH; i++) begin
      store_re[i] = '0;
      store_im[i] = '0;
    end
    store_re[0] = Q_ONE;
  endtask

  task automatic gate_store(input int tq, input int cq, input bit uc);
    int tmask;
    int cmask;
    logic signed [31:0] ar, ai, br, bi;
    tmask = 0;
    cmask = 0;
    if (tq >= NUM_QUBITS) return;
    if (uc && (cq >= NUM_QUBITS || cq == tq)) return;
    tmask = 1 << (NUM_QUBITS - 1 - tq);
    if (uc) cmask = 1 << (NUM_QUBITS - 1 - cq);
    for (int i = 0; i < DEPTH; i++) begin
      if ((i & tmask) == 0 && (i & cmask) == cmask) begin
        ar = store_re[i];
        ai = store_im[i];
        br = store_re[i|tmask];
        bi = store_im[i|tmask];
        mix_pair(0, 2, ar, ai, br, bi, store_re[i], store_im[i]);
        mix_pair(4, 6, ar, ai, br, bi, store_re[i|tmask], store_im[i|tmask]);
      end
    end
  endtask

  function automatic logic [30:0] zero_weight(input int tq);
    logic [79:0] acc;
    logic [79:0] r;
    int tmask;
    acc = '0;
    tmask = (tq < NUM_QUBITS) ? (1 << (NUM_QUBITS - 1 - tq)) : 0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((i & tmask) == 0)
        acc = acc + 80'(longint'(store_re[i]) * longint'(store_re[i]))
                  + 80'(longint'(store_im[i]) * longint'(store_im[i]));
    end
    r = (acc + 80'd536870912) >> 30;
    if (r > 80'h7FFF_FFFF) return PROB_SAT;
    return r[30:0];
  endfunction

  // ---------------- driving ----------------
  task automatic send_item(input op_t o, input logic [3:0] tq, input logic [3:0] cq,
                           input bit uc, input logic [9:0] idx);
    outcome_t e;
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    target_qubit <= tq;
    control_qubit <= cq;
    use_control <= uc;
    amp_index <= idx;
    do @(posedge clk); while (!in_ready);
    e = '{op: o, re: '0, im: '0, prob: '0};
    case (o)
      OP_INIT: clear_store();
      OP_GATE: gate_store(tq, cq, uc);
      OP_READ: begin
        e.re = store_re[idx];
        e.im = store_im[idx];
      end
      OP_PROB: e.prob = zero_weight(tq);
      default: begin
      end
    endcase
    outcome_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (outcome_q.size() == 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_gate(input logic [31:0] v [NUM_REGS]);
    settle();
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_IDX[k];
      cfg_data <= v[k];
      do @(posedge clk); while (!cfg_ready);
      gate_m[k] = v[k];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------- receiving and checking ----------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing expected: done_op %0d", done_op);
        errors++;
      end else begin
        e = outcome_q.pop_front();
        if (done_op !== e.op) begin
          $error("done_op expected %0d actual %0d", e.op, done_op);
          errors++;
        end
        if (amp_real !== e.re) begin
          $error("amp_real expected %h actual %h", e.re, amp_real);
          errors++;
        end
        if (amp_imag !== e.im) begin
          $error("amp_imag expected %h actual %h", e.im, amp_imag);
          errors++;
        end
        if (prob_zero !== e.prob) begin
          $error("prob_zero expected %h actual %h", e.prob, prob_zero);
          errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_state();
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd0);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd1023);
    send_item(OP_PROB, 4'd0, 4'd0, 1'b0, 10'd0);
    send_item(OP_PROB, 4'd15, 4'd0, 1'b0, 10'd0);
    send_item(OP_GATE, 4'd9, 4'd0, 1'b0, 10'd0);
  endtask

  task automatic test_gates();
    set_gate('{HADA, 0, HADA, 0, HADA, 0, -HADA, 0});
    send_item(OP_GATE, 4'd0, 4'd0, 1'b0, 10'd0);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd512);
    send_item(OP_PROB, 4'd0, 4'd0, 1'b0, 10'd0);
    // target beyond the store leaves it alone
    send_item(OP_GATE, 4'd12, 4'd0, 1'b0, 10'd0);
    send_item(OP_GATE, 4'd9, 4'd0, 1'b1, 10'd0);
    send_item(OP_GATE, 4'd3, 4'd3, 1'b1, 10'd0);
    send_item(OP_GATE, 4'd3, 4'd15, 1'b1, 10'd0);
    send_item(OP_PROB, 4'd9, 4'd0, 1'b0, 10'd0);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd513);
    send_item(OP_INIT, 4'd15, 4'd15, 1'b1, 10'h3FF);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd512);
  endtask

  task automatic test_extremes();
    set_gate('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_item(OP_GATE, 4'd9, 4'd0, 1'b0, 10'd0);
    send_item(OP_GATE, 4'd4, 4'd9, 1'b0, 10'd0);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd1);
    set_gate('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_item(OP_GATE, 4'd0, 4'd0, 1'b0, 10'd0);
    send_item(OP_PROB, 4'd5, 4'd0, 1'b0, 10'd0);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd768);
    send_item(OP_INIT, 4'd0, 4'd0, 1'b0, 10'd0);
  endtask

  task automatic test_random_phase(input int n);
    int r;
    logic [3:0] tq;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      tq = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      if (r < 4)
        send_item(OP_INIT, 4'($urandom), 4'($urandom), 1'($urandom), 10'($urandom));
      else if (r < 24)
        send_item(OP_GATE, tq, ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                  : 4'($urandom_range(9)), 1'($urandom), 10'($urandom));
      else if (r < 38)
        send_item(OP_PROB, tq, 4'($urandom), 1'($urandom), 10'($urandom));
      else
        send_item(OP_READ, 4'($urandom), 4'($urandom), 1'($urandom), 10'($urandom));
    end
  endtask

  task automatic test_random();
    logic [31:0] v [NUM_REGS];
    quiet = 1'b1;
    set_gate('{HADA, 0, HADA, 0, HADA, 0, -HADA, 0});
    test_random_phase(RAND_ITEMS / 5);
    quiet = 1'b0;
    // X with a phase on the lower row
    set_gate('{0, 0, Q_ONE, 0, 0, Q_ONE, 0, 0});
    test_random_phase(RAND_ITEMS / 5);
    set_gate('{Q_ONE, 0, 0, 0, 0, 0, 0, Q_ONE});
    test_random_phase(RAND_ITEMS / 5);
    for (int k = 0; k < NUM_REGS; k++) v[k] = $urandom;
    set_gate(v);
    test_random_phase(RAND_ITEMS / 5);
    for (int k = 0; k < NUM_REGS; k++) v[k] = 32'($signed(26'($urandom)));
    set_gate(v);
    test_random_phase(RAND_ITEMS / 5);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'($urandom));
    // hold the sender until the pipe has drained
    in_valid <= 1'b0;
    wait (outcome_q.size() == 0);
    @(negedge clk);
    send_item(OP_PROB, 4'd2, 4'd0, 1'b0, 10'd0);
  endtask

  task automatic test_spare_index();
    // an index past the register file must change nothing
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= 4'hF;
    cfg_data <= 32'hFFFF_FFFF;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= 4'h8;
    cfg_data <= 32'h0;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_item(OP_GATE, 4'd1, 4'd0, 1'b0, 10'd0);
    send_item(OP_READ, 4'd0, 4'd0, 1'b0, 10'd0);
  endtask

  initial begin
    gate_m = '{Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0};
    clear_store();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_gates();
    test_extremes();
    test_spare_index();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    wait (outcome_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/svg_pkg.sv
hw/rtl/svg_amp_ram.sv
hw/rtl/svg_gate_mac.sv
hw/rtl/svg_prob_acc.sv
hw/rtl/state_vector_gate_engine.sv
tb/testbench.sv
